@@ design/ptpm_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptpm_pkg
// Shared types and constants of the pulse timing pattern matcher: transaction
// structs, command classes, opcodes and the execution state encoding.
// ============================================================================
package ptpm_pkg;

    localparam int NUM_PATTERNS_DEF = 8;
    localparam int MAX_WORDS_DEF    = 64;
    localparam int TIMING_BITS_DEF  = 16;

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef enum logic [1:0] {
        CMD_EDGE,
        CMD_WRITE,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef enum logic {
        BK_DISPATCH,
        BK_MATCH
    } back_state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] edge_time;
        logic [2:0]  pattern_sel;
        logic [5:0]  word_position;
        logic [15:0] low_bound;
        logic [15:0] high_bound;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [7:0] detected_mask;
        logic       accepted;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] edge_time;
        logic [2:0]  pattern_sel;
        logic [5:0]  word_position;
        logic [15:0] low_bound;
        logic [15:0] high_bound;
        logic        last_word;
    } cmd_t;

endpackage

@@ design/ptpm_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptpm_front
// Accepts input transactions, classifies them into commands (out-of-range
// writes become no-ops) and holds them in a two-entry command queue.
// ============================================================================
module ptpm_front #(
    parameter int NUM_PATTERNS = 8,
    parameter int MAX_WORDS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ptpm_pkg::in_item_t command,
    output logic               cmd_valid,
    input  logic               cmd_pop,
    output ptpm_pkg::cmd_t     cmd
);
    import ptpm_pkg::*;

    cmd_t       cmd_in;
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       in_fire;
    logic       out_fire;
    logic       in_range;

    assign in_range = (4'({1'b0, command.pattern_sel}) < 4'(NUM_PATTERNS))
                   && (7'(command.word_position) < 7'(MAX_WORDS));

    always_comb
    begin
        cmd_in.edge_time     = command.edge_time;
        cmd_in.pattern_sel   = command.pattern_sel;
        cmd_in.word_position = command.word_position;
        cmd_in.low_bound     = command.low_bound;
        cmd_in.high_bound    = command.high_bound;
        cmd_in.last_word     = command.last_word;
        unique case (command.opcode)
            OP_EDGE:  cmd_in.kind = CMD_EDGE;
            OP_WRITE: cmd_in.kind = in_range ? CMD_WRITE : CMD_NOP;
            OP_CLEAR: cmd_in.kind = CMD_CLEAR;
            OP_NONE:  cmd_in.kind = CMD_NOP;
            default:  cmd_in.kind = CMD_NOP;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign in_fire   = push && !full;
    assign out_fire  = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = in_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_fire ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({in_fire, out_fire})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_head_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (count_reg == 2'd0) |=> cmd_valid)
        else $error("command queue lost a transaction");
`endif

endmodule

@@ design/ptpm_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptpm_back
// Executes commands: bound memory writes with window widening, clears, and
// edge matching over all patterns (memory read, then compare and update).
// ============================================================================
module ptpm_back #(
    parameter int NUM_PATTERNS = 8,
    parameter int MAX_WORDS    = 64,
    parameter int TIMING_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ptpm_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output ptpm_pkg::out_item_t res_item
);
    import ptpm_pkg::*;

    localparam int IDX_W   = $clog2(MAX_WORDS + 1);
    localparam int WORD_AW = $clog2(MAX_WORDS);

    typedef logic [TIMING_BITS-1:0] bound_t;
    typedef logic [IDX_W-1:0]       idx_t;

    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        cur_reg;

    idx_t        plen_reg  [NUM_PATTERNS];
    idx_t        plen_next [NUM_PATTERNS];
    idx_t        midx_reg  [NUM_PATTERNS];
    idx_t        midx_next [NUM_PATTERNS];
    bound_t      win_lo_reg;
    bound_t      win_lo_next;
    bound_t      win_hi_reg;
    bound_t      win_hi_next;
    logic        win_valid_reg;
    logic        win_valid_next;
    logic [31:0] prev_edge_reg;
    logic [31:0] prev_edge_next;

    bound_t      lo_in;
    bound_t      hi_in;
    logic        dispatch;
    logic        read_en;
    logic        write_en;
    logic [31:0] gap;
    logic        in_win;
    logic [NUM_PATTERNS-1:0] mask;
    logic [NUM_PATTERNS-1:0] fit_cur;
    logic [NUM_PATTERNS-1:0] fit_first;

    assign lo_in    = TIMING_BITS'(cmd.low_bound);
    assign hi_in    = TIMING_BITS'(cmd.high_bound);
    assign dispatch = (state_reg == BK_DISPATCH) && cmd_valid && !res_full;
    assign cmd_pop  = dispatch;
    assign read_en  = dispatch && (cmd.kind == CMD_EDGE);
    assign write_en = dispatch && (cmd.kind == CMD_WRITE);

    assign gap    = cur_reg.edge_time - prev_edge_reg;
    assign in_win = win_valid_reg && (gap > 32'(win_lo_reg)) && (gap < 32'(win_hi_reg));

    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_pat
        logic [2*TIMING_BITS-1:0] mem [MAX_WORDS];
        logic [2*TIMING_BITS-1:0] rd_reg;
        bound_t                   first_lo_reg;
        bound_t                   first_hi_reg;
        logic                     sel_hit;

        assign sel_hit = write_en && (cmd.pattern_sel == 3'(p));

        always_ff @(posedge clk)
        begin
            if (sel_hit)
            begin
                mem[cmd.word_position[WORD_AW-1:0]] <= {hi_in, lo_in};
            end
            if (read_en)
            begin
                rd_reg <= mem[midx_reg[p][WORD_AW-1:0]];
            end
        end

        always_ff @(posedge clk)
        begin
            if (sel_hit && (cmd.word_position == 6'd0))
            begin
                first_lo_reg <= lo_in;
                first_hi_reg <= hi_in;
            end
        end

        assign fit_cur[p]   = (gap > 32'(rd_reg[TIMING_BITS-1:0]))
                           && (gap < 32'(rd_reg[2*TIMING_BITS-1:TIMING_BITS]));
        assign fit_first[p] = (gap > 32'(first_lo_reg)) && (gap < 32'(first_hi_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_DISPATCH:
            begin
                if (read_en)
                begin
                    state_next = BK_MATCH;
                end
            end
            BK_MATCH: state_next = BK_DISPATCH;
            default:  state_next = BK_DISPATCH;
        endcase
    end

    always_comb
    begin
        win_lo_next    = win_lo_reg;
        win_hi_next    = win_hi_reg;
        win_valid_next = win_valid_reg;
        prev_edge_next = prev_edge_reg;
        mask           = '0;
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            plen_next[p] = plen_reg[p];
            midx_next[p] = midx_reg[p];
        end

        if (state_reg == BK_MATCH)
        begin
            prev_edge_next = cur_reg.edge_time;
            if (in_win)
            begin
                for (int p = 0; p < NUM_PATTERNS; p++)
                begin
                    if (plen_reg[p] != '0)
                    begin
                        if (midx_reg[p] < plen_reg[p])
                        begin
                            if (fit_cur[p])
                            begin
                                midx_next[p] = midx_reg[p] + idx_t'(1);
                            end
                            else if (fit_first[p])
                            begin
                                midx_next[p] = idx_t'(1);
                            end
                            else
                            begin
                                midx_next[p] = '0;
                            end
                        end
                        else
                        begin
                            mask[p]      = 1'b1;
                            midx_next[p] = '0;
                        end
                    end
                end
            end
        end
        else if (dispatch)
        begin
            unique case (cmd.kind)
                CMD_WRITE:
                begin
                    win_valid_next = 1'b1;
                    if (!win_valid_reg || (lo_in < win_lo_reg))
                    begin
                        win_lo_next = lo_in;
                    end
                    if (!win_valid_reg || (hi_in > win_hi_reg))
                    begin
                        win_hi_next = hi_in;
                    end
                    for (int p = 0; p < NUM_PATTERNS; p++)
                    begin
                        if (cmd.pattern_sel == 3'(p))
                        begin
                            midx_next[p] = '0;
                            if (cmd.last_word)
                            begin
                                plen_next[p] = idx_t'(cmd.word_position) + idx_t'(1);
                            end
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    win_lo_next    = '0;
                    win_hi_next    = '0;
                    win_valid_next = 1'b0;
                    for (int p = 0; p < NUM_PATTERNS; p++)
                    begin
                        plen_next[p] = '0;
                        midx_next[p] = '0;
                    end
                end
                CMD_EDGE, CMD_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_push               = (state_reg == BK_MATCH) || (dispatch && !read_en);
    assign res_item.detected_mask = (state_reg == BK_MATCH) ? 8'(mask) : 8'd0;
    assign res_item.accepted      = (state_reg == BK_MATCH) && in_win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_DISPATCH;
            win_lo_reg    <= '0;
            win_hi_reg    <= '0;
            win_valid_reg <= 1'b0;
            prev_edge_reg <= '0;
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                plen_reg[p] <= '0;
                midx_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            win_lo_reg    <= win_lo_next;
            win_hi_reg    <= win_hi_next;
            win_valid_reg <= win_valid_next;
            prev_edge_reg <= prev_edge_next;
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                plen_reg[p] <= plen_next[p];
                midx_reg[p] <= midx_next[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_en)
        begin
            cur_reg <= cmd;
        end
    end

`ifndef SYNTHESIS
    a_match_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MATCH) |-> $past(read_en))
        else $error("match phase without a memory read");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_accept_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_item.accepted |-> win_valid_reg)
        else $error("gap accepted with no window loaded");

    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_chk
        a_index_in_length: assert property (@(posedge clk) disable iff (!rst_n)
            midx_reg[p] <= plen_reg[p])
            else $error("match index beyond pattern length");
    end
`endif

endmodule

@@ design/ptpm_res_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptpm_res_queue
// Two-entry result queue that decouples the execution unit from the consumer.
// ============================================================================
module ptpm_res_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                put,
    input  ptpm_pkg::out_item_t put_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output ptpm_pkg::out_item_t result
);
    import ptpm_pkg::*;

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       in_fire;
    logic       out_fire;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign result   = slot_reg[rd_ptr_reg];
    assign in_fire  = put && !full;
    assign out_fire = pop && !empty;

    always_comb
    begin
        wr_ptr_next = in_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_fire ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({in_fire, out_fire})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot_reg[wr_ptr_reg] <= put_item;
        end
    end

`ifndef SYNTHESIS
    a_fill_to_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !out_fire && (count_reg == 2'd1) |=> full)
        else $error("result queue count out of step");
`endif

endmodule

@@ design/pulse_timing_pattern_matcher.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pulse_timing_pattern_matcher
// Edge-timestamp pulse matcher: keeps inter-edge gaps inside the acceptance
// window and tracks up to NUM_PATTERNS timing patterns, flagging completions.
//
//   Channel   Handshake      Payload        Transaction
//   input     push / full    command        edge, pattern word write, clear
//   output    pop / empty    result         detected mask and accepted flag
//
// An edge is executed as the synchronous read of the per-pattern bound
// memories in BK_DISPATCH, then compare and index update in BK_MATCH.
// Writes, clears and unused opcodes finish in BK_DISPATCH. Two-entry command
// and result queues let input and output stall independently. Reset clears
// lengths, indexes, window and previous edge at once; bound memories are
// undefined until written and need no clearing pass.
// ============================================================================
module pulse_timing_pattern_matcher #(
    parameter int NUM_PATTERNS = ptpm_pkg::NUM_PATTERNS_DEF,
    parameter int MAX_WORDS    = ptpm_pkg::MAX_WORDS_DEF,
    parameter int TIMING_BITS  = ptpm_pkg::TIMING_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ptpm_pkg::in_item_t  command,
    output logic                empty,
    input  logic                pop,
    output ptpm_pkg::out_item_t result
);
    import ptpm_pkg::*;

    cmd_t      cmd;
    logic      cmd_valid;
    logic      cmd_pop;
    logic      res_full;
    logic      res_push;
    out_item_t res_item;

    ptpm_front #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_WORDS    (MAX_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    ptpm_back #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_WORDS    (MAX_WORDS),
        .TIMING_BITS  (TIMING_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    ptpm_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .put      (res_push),
        .put_item (res_item),
        .full     (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

@@ dv/tb_pulse_timing_pattern_matcher.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_pulse_timing_pattern_matcher
// Drives edge, pattern write, clear and unused commands into the matcher and
// checks every result against a cycle-free model of the gap window, the
// per-pattern match indexes and the detected mask. A short directed sequence
// covers bound and wrap corners; random traffic then loads patterns, plays
// matching gap trains, broken trains and noise under three idling profiles,
// with one long output hold-off that backs up the input queue.
// ============================================================================
module tb_pulse_timing_pattern_matcher;
    import ptpm_pkg::*;

    localparam int NPAT        = NUM_PATTERNS_DEF;
    localparam int NWORD       = MAX_WORDS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 10;
    localparam int PHASE_ITEMS = 140;
    localparam int REPORT_MAX  = 10;

    class match_scoreboard;
        logic [15:0] low_mem   [NPAT*NWORD];
        logic [15:0] high_mem  [NPAT*NWORD];
        int          pat_len   [NPAT];
        int          match_idx [NPAT];
        logic [15:0] win_low;
        logic [15:0] win_high;
        bit          win_valid;
        logic [31:0] last_edge;
        out_item_t   expected_q [$];
        int          mismatches;

        function new();
            clear_patterns();
            last_edge  = '0;
            mismatches = 0;
        endfunction

        function void clear_patterns();
            foreach (pat_len[p])
            begin
                pat_len[p]   = 0;
                match_idx[p] = 0;
            end
            win_low   = '0;
            win_high  = '0;
            win_valid = 1'b0;
        endfunction

        function bit word_fits(logic [31:0] gap, int addr);
            return (gap > {16'd0, low_mem[addr]}) && (gap < {16'd0, high_mem[addr]});
        endfunction

        function void note_command(in_item_t cmd);
            out_item_t   want;
            logic [31:0] gap;
            int          base;
            want = '0;
            case (cmd.opcode)
                OP_EDGE:
                begin
                    gap       = cmd.edge_time - last_edge;
                    last_edge = cmd.edge_time;
                    if (win_valid && gap > {16'd0, win_low} && gap < {16'd0, win_high})
                    begin
                        want.accepted = 1'b1;
                        for (int p = 0; p < NPAT; p++)
                        begin
                            base = p * NWORD;
                            if (pat_len[p] != 0)
                            begin
                                if (match_idx[p] < pat_len[p])
                                begin
                                    if (word_fits(gap, base + match_idx[p]))
                                        match_idx[p] = match_idx[p] + 1;
                                    else if (word_fits(gap, base))
                                        match_idx[p] = 1;
                                    else
                                        match_idx[p] = 0;
                                end
                                else
                                begin
                                    want.detected_mask[p] = 1'b1;
                                    match_idx[p] = 0;
                                end
                            end
                        end
                    end
                end
                OP_WRITE:
                begin
                    base = int'(cmd.pattern_sel) * NWORD + int'(cmd.word_position);
                    low_mem[base]  = cmd.low_bound;
                    high_mem[base] = cmd.high_bound;
                    if (!win_valid)
                    begin
                        win_low   = cmd.low_bound;
                        win_high  = cmd.high_bound;
                        win_valid = 1'b1;
                    end
                    else
                    begin
                        if (cmd.low_bound < win_low)
                            win_low = cmd.low_bound;
                        if (cmd.high_bound > win_high)
                            win_high = cmd.high_bound;
                    end
                    match_idx[cmd.pattern_sel] = 0;
                    if (cmd.last_word)
                        pat_len[cmd.pattern_sel] = int'(cmd.word_position) + 1;
                end
                OP_CLEAR:
                    clear_patterns();
                default:
                    ;
            endcase
            expected_q.push_back(want);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected result: mask=%h accepted=%b",
                             $realtime, got.detected_mask, got.accepted);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.detected_mask !== want.detected_mask ||
                    got.accepted !== want.accepted)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] mismatch: expected mask=%h accepted=%b, got mask=%h accepted=%b",
                                 $realtime, want.detected_mask, want.accepted,
                                 got.detected_mask, got.accepted);
                end
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void flush_leftovers();
            if (expected_q.size() != 0)
            begin
                $display("%0d results never arrived", expected_q.size());
                mismatches += expected_q.size();
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  command;
    logic      empty;
    logic      pop;
    out_item_t result;

    match_scoreboard board;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int          stall_cycles = 0;
    int          item_count;
    logic [31:0] stamp;
    logic [15:0] word_low  [NPAT*NWORD];
    logic [15:0] word_high [NPAT*NWORD];
    bit          word_seen [NPAT*NWORD];
    int          loaded_len [NPAT];

    pulse_timing_pattern_matcher u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .command (command),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            board.note_command(command);
        if (rst_n && pop && !empty)
            board.check_result(result);
        if (rst_n && ((push && !full) || (pop && !empty)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("Verification failed");
        $finish;
    end

    // hold off the output on request, otherwise pop at the current rate
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_item_t random_item();
        in_item_t it;
        it.opcode        = 2'($urandom);
        it.edge_time     = $urandom;
        it.pattern_sel   = 3'($urandom);
        it.word_position = 6'($urandom);
        it.low_bound     = 16'($urandom);
        it.high_bound    = 16'($urandom);
        it.last_word     = 1'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] fitting_gap(int addr);
        int lo;
        int hi;
        lo = int'(word_low[addr]);
        hi = int'(word_high[addr]);
        if (hi - lo >= 2)
            return $urandom_range(hi - 1, lo + 1);
        return $urandom_range(5000, 1);
    endfunction

    function automatic int pick_loaded();
        int cand [$];
        for (int p = 0; p < NPAT; p++)
            if (loaded_len[p] != 0)
                cand.push_back(p);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        command <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (it.opcode != OP_NONE)
            item_count++;
    endtask

    task automatic do_edge_at(logic [31:0] t);
        in_item_t it;
        it           = random_item();
        it.opcode    = OP_EDGE;
        it.edge_time = t;
        stamp        = t;
        send_item(it);
    endtask

    task automatic do_edge(logic [31:0] gap);
        do_edge_at(stamp + gap);
    endtask

    // hold last_word low until every earlier word of the pattern is written
    task automatic do_write(int p, int pos, logic [15:0] lo, logic [15:0] hi, bit last);
        in_item_t it;
        int       base;
        bit       ready;
        base  = p * NWORD;
        ready = 1'b1;
        for (int w = 0; w < pos; w++)
            if (!word_seen[base + w])
                ready = 1'b0;
        it               = random_item();
        it.opcode        = OP_WRITE;
        it.pattern_sel   = 3'(p);
        it.word_position = 6'(pos);
        it.low_bound     = lo;
        it.high_bound    = hi;
        it.last_word     = last && ready;
        word_low[base + pos]  = lo;
        word_high[base + pos] = hi;
        word_seen[base + pos] = 1'b1;
        if (it.last_word)
            loaded_len[p] = pos + 1;
        send_item(it);
    endtask

    task automatic do_op(logic [1:0] op);
        in_item_t it;
        it        = random_item();
        it.opcode = op;
        if (op == OP_CLEAR)
            foreach (loaded_len[p])
                loaded_len[p] = 0;
        send_item(it);
    endtask

    task automatic load_pattern(int p, int n);
        logic [15:0] lo;
        for (int w = 0; w < n; w++)
        begin
            lo = 16'($urandom_range(4000, 20));
            do_write(p, w, lo, 16'(lo + $urandom_range(600, 2)), w == n - 1);
        end
    endtask

    task automatic play_pattern(int p, int upto);
        for (int w = 0; w < upto; w++)
            do_edge(fitting_gap(p * NWORD + w));
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int count, bit with_long);
        int start;
        int r;
        int p;
        start = item_count;
        if (with_long)
        begin
            p = int'($urandom_range(NPAT - 1));
            load_pattern(p, NWORD);
            play_pattern(p, NWORD);
            do_edge(fitting_gap(p * NWORD));
        end
        while (item_count - start < count)
        begin
            r = int'($urandom_range(99));
            p = pick_loaded();
            if (r < 6)
            begin
                do_op(OP_CLEAR);
                repeat ($urandom_range(3, 1))
                    load_pattern(int'($urandom_range(NPAT - 1)),
                                 int'($urandom_range(6, 1)));
            end
            else if (r < 14 || p < 0)
                load_pattern(int'($urandom_range(NPAT - 1)), int'($urandom_range(6, 1)));
            else if (r < 58)
            begin
                play_pattern(p, loaded_len[p]);
                do_edge(fitting_gap(p * NWORD));
            end
            else if (r < 68)
            begin
                play_pattern(p, int'($urandom_range(loaded_len[p] - 1, 0)));
                do_edge($urandom_range(70000, 0));
            end
            else if (r < 78)
                do_edge($urandom_range(8000, 0));
            else if (r < 82)
                do_edge_at($urandom);
            else if (r < 92)
                do_write(int'($urandom_range(NPAT - 1)), int'($urandom_range(NWORD - 1)),
                         16'($urandom), 16'($urandom), 1'($urandom_range(1)));
            else if (r < 96)
                do_op(OP_NONE);
            else
                do_op(OP_CLEAR);
        end
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        push          = 1'b0;
        command       = '0;
        send_idle_pct = 7;
        recv_idle_pct = 81;
        hold_req      = 1'b0;
        item_count    = 0;
        stamp         = '0;
        foreach (loaded_len[p])
            loaded_len[p] = 0;
        foreach (word_seen[a])
            word_seen[a] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        do_edge_at(32'd100);
        do_op(OP_NONE);
        do_op(OP_CLEAR);
        do_write(NPAT - 1, NWORD - 1, 16'h0000, 16'hFFFF, 1'b0);
        do_edge_at(32'hFFFF_FFFF);
        do_edge(32'd5);
        do_write(0, 0, 16'd100, 16'd200, 1'b0);
        do_write(0, 1, 16'd300, 16'd400, 1'b1);
        do_edge(32'd150);
        do_edge(32'd350);
        do_edge(32'd150);
        do_edge(32'd350);
        do_edge(32'd150);
        do_edge(32'd150);
        do_edge(32'd350);
        do_write(0, 0, 16'd100, 16'd200, 1'b0);
        do_edge(32'd100);
        do_edge(32'd0);
        do_edge(32'd65535);
        do_edge(32'd65534);
        do_op(OP_CLEAR);
        do_edge(32'd150);
        do_write(1, 0, 16'd0, 16'd0, 1'b1);
        do_edge(32'd7);
        wait_drain();

        run_phase(PHASE_ITEMS, 1'b0);
        wait_drain();

        send_idle_pct = 81;
        recv_idle_pct = 7;
        run_phase(PHASE_ITEMS, 1'b0);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (16) do_edge($urandom_range(8000, 0));
        wait_drain();
        run_phase(PHASE_ITEMS, 1'b1);
        wait_drain();

        board.flush_leftovers();
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
